// ===== rtl/tm_pkg.sv =====
package tm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int TRIM_W   = 6;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean;
      logic                mean_valid;
      logic                overflowed;
   } rsp_type;

endpackage

// ===== rtl/trimmed_mean.sv =====
// Samples are taken one beat a cycle while idle; the beat marked last closes the run.
// After the last beat, if more than twice the trim count of samples are stored, each
// sample is ranked by one comparator sweeping the store, then a bit-serial divider
// produces one quotient bit per cycle from the SW-bit sum.
// Input is stalled from the last beat until the result is in the output register.
// Synchronous reset clears the run state, the trim count and the output valid.
module trimmed_mean #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tm_pkg::req_type           req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tm_pkg::rsp_type           rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [tm_pkg::TRIM_W-1:0] csr_data
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int XW = ((CW > tm_pkg::TRIM_W + 1) ? CW : tm_pkg::TRIM_W + 1) + 1;
   localparam int SW = tm_pkg::SAMPLE_W + AW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_KEY   = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_ACC   = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [tm_pkg::SAMPLE_W-1:0] mem [MAX_SAMPLES];

   logic [2:0]                  state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        drop_ff, drop_in;
   logic [tm_pkg::TRIM_W-1:0]   trim_ff, trim_in;
   logic [AW-1:0]               i_ff, i_in;
   logic [AW-1:0]               cj_ff, cj_in;
   logic [CW-1:0]               rank_ff, rank_in;
   logic [tm_pkg::SAMPLE_W-1:0] key_ff, key_in;
   logic [SW-1:0]               sum_ff, sum_in;
   logic [XW-1:0]               hi_ff, hi_in;
   logic [CW-1:0]               divd_ff, divd_in;
   logic [tm_pkg::SAMPLE_W-1:0] mean_ff, mean_in;
   logic                        mvalid_ff, mvalid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tm_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [tm_pkg::SAMPLE_W-1:0] rd_data_ff;

   logic          accept;
   logic          store_ok;
   logic [AW-1:0] rd_addr;
   logic          less;
   logic          kept;
   logic          last_idx;
   logic          div_start;
   logic          div_done;
   logic [SW-1:0] div_q;

   assign accept   = req_valid && !req_stall;
   assign store_ok = count_ff != CW'(MAX_SAMPLES);
   assign less     = (rd_data_ff < key_ff) || ((rd_data_ff == key_ff) && (cj_ff < i_ff));
   assign kept     = (XW'(rank_ff) >= XW'(trim_ff)) && (XW'(rank_ff) < hi_ff);
   assign last_idx = CW'(i_ff) == (count_ff - CW'(1));

   always_comb begin
      unique case (state_ff)
         ST_LOAD: rd_addr = '0;
         ST_SCAN: rd_addr = cj_ff + AW'(1);
         default: rd_addr = i_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      trim_in      = trim_ff;
      i_in         = i_ff;
      cj_in        = cj_ff;
      rank_in      = rank_ff;
      key_in       = key_ff;
      sum_in       = sum_ff;
      hi_in        = hi_ff;
      divd_in      = divd_ff;
      mean_in      = mean_ff;
      mvalid_in    = mvalid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;

      if (csr_valid) begin
         trim_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (store_ok) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_data.last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (XW'(count_ff) > (XW'(trim_ff) << 1)) begin
               i_in     = '0;
               sum_in   = '0;
               hi_in    = XW'(count_ff) - XW'(trim_ff);
               divd_in  = CW'(XW'(count_ff) - (XW'(trim_ff) << 1));
               state_in = ST_KEY;
            end else begin
               mean_in   = '0;
               mvalid_in = 1'b0;
               state_in  = ST_OUT;
            end
         end
         ST_KEY: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            key_in   = rd_data_ff;
            cj_in    = '0;
            rank_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rank_in = rank_ff + CW'(less);
            cj_in   = cj_ff + AW'(1);
            if (CW'(cj_ff) == (count_ff - CW'(1))) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (kept) begin
               sum_in = sum_ff + SW'(key_ff);
            end
            if (last_idx) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = ST_KEY;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in   = div_q[tm_pkg::SAMPLE_W-1:0];
               mvalid_in = 1'b1;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.mean       = mean_ff;
               rsp_data_in.mean_valid = mvalid_ff;
               rsp_data_in.overflowed = drop_ff;
               count_in               = '0;
               drop_in                = 1'b0;
               state_in               = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         trim_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         trim_ff      <= trim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      cj_ff       <= cj_in;
      rank_ff     <= rank_in;
      key_ff      <= key_in;
      sum_ff      <= sum_in;
      hi_ff       <= hi_in;
      divd_ff     <= divd_in;
      mean_ff     <= mean_in;
      mvalid_ff   <= mvalid_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (accept && store_ok) begin
         mem[count_ff[AW-1:0]] <= req_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   tm_div #(
      .NW(SW),
      .DW(CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (divd_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== rtl/tm_div.sv =====
module tm_div #(
   parameter int NW = 38,
   parameter int DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CNTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW:0]     shifted;
   logic [DW:0]     diff;
   logic            fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(NW);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? diff[DW-1:0] : shifted[DW-1:0];
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/tm_check.sv =====
module tm_check (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input tm_pkg::req_type           req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input tm_pkg::rsp_type           rsp_data
);

   // The beat that closes a run holds off further input while the run is reduced.
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.last) |=> req_stall)
      else $error("input not stalled after the closing beat");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.mean_valid) |-> (rsp_data.mean == '0))
      else $error("mean not zero on a short run");

   a_result_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a closed run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

bind trimmed_mean tm_check u_tm_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_top.sv =====
module tb_top;

   localparam int SAMPLE_W       = tm_pkg::SAMPLE_W;
   localparam int TRIM_W         = tm_pkg::TRIM_W;
   localparam int STORE_DEPTH    = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_SAMPLES = 800;
   localparam logic [TRIM_W-1:0] TRIM_NONE = '0;
   localparam logic [TRIM_W-1:0] TRIM_MAX  = '1;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   tm_pkg::req_type     req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   tm_pkg::rsp_type     rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [TRIM_W-1:0]   csr_data  = '0;

   logic [TRIM_W-1:0]   trim_setting = '0;
   logic [SAMPLE_W-1:0] run_store [STORE_DEPTH];
   int                  run_len      = 0;
   logic                run_dropped  = 1'b0;
   logic [37:0]         run_total    = '0;
   tm_pkg::rsp_type     expected_means [$];

   int                  mismatches    = 0;
   int                  idle_cycles   = 0;
   int                  samples_sent  = 0;
   logic                sender_eager  = 1'b0;

   trimmed_mean #(
      .MAX_SAMPLES(STORE_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 90);
   endfunction

   function automatic logic [SAMPLE_W-1:0] sample_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom;
      if (r < 75) return $urandom_range(0, 15);
      if (r < 85) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      return 32'hFFFF_FF00 | $urandom_range(0, 255);
   endfunction

   // Ranks the stored run, strips the trimmed ends from the total and divides.
   function automatic tm_pkg::rsp_type close_run();
      logic [SAMPLE_W-1:0] ordered [STORE_DEPTH];
      logic [SAMPLE_W-1:0] key;
      logic [37:0]         kept;
      int                  n, t, i, j;
      tm_pkg::rsp_type     r;
      n = run_len;
      t = trim_setting;
      r.mean       = '0;
      r.mean_valid = 1'b0;
      r.overflowed = run_dropped;
      if (n > 2 * t) begin
         for (i = 0; i < n; i++) ordered[i] = run_store[i];
         for (i = 1; i < n; i++) begin
            key = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > key) begin
               ordered[j] = ordered[j-1];
               j--;
            end
            ordered[j] = key;
         end
         kept = run_total;
         for (i = 0; i < t; i++) begin
            kept = kept - ordered[i];
            kept = kept - ordered[n-1-i];
         end
         r.mean       = SAMPLE_W'(kept / 38'(n - 2 * t));
         r.mean_valid = 1'b1;
      end
      run_len     = 0;
      run_dropped = 1'b0;
      run_total   = '0;
      return r;
   endfunction

   task automatic take_sample(input logic [SAMPLE_W-1:0] s, input logic lst);
      if (run_len < STORE_DEPTH) begin
         run_store[run_len] = s;
         run_len++;
         run_total = run_total + s;
      end else begin
         run_dropped = 1'b1;
      end
      if (lst) expected_means.push_back(close_run());
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic lst);
      int gap;
      gap = sender_eager ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample: s, last: lst};
      do @(posedge clock); while (req_stall);
      samples_sent++;
      take_sample(s, lst);
   endtask

   task automatic send_run(input int n);
      int i;
      for (i = 0; i < n; i++) send_sample(sample_value(), i == n - 1);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_trim(input logic [TRIM_W-1:0] t);
      csr_valid <= 1'b1;
      csr_data  <= t;
      do @(posedge clock); while (!csr_ready);
      trim_setting = t;
      csr_valid <= 1'b0;
   endtask

   // Extreme samples, single-beat runs and runs too short for the trim.
   task automatic test_directed();
      send_sample(32'h0, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0, 1'b1);
      drain_results();
      write_trim(6'd1);
      send_sample(32'd5, 1'b0);
      send_sample(32'd7, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0, 1'b0);
      send_sample(32'h1234_5678, 1'b1);
      drain_results();
      write_trim(TRIM_MAX);
      send_sample(32'hAAAA_5555, 1'b0);
      send_sample(32'h5555_AAAA, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      drain_results();
      write_trim(6'd32);
      send_sample(32'h0001_0000, 1'b0);
      send_sample(32'hFFFF_0000, 1'b0);
      send_sample(32'h0000_FFFF, 1'b1);
      drain_results();
   endtask

   // A run that fills the store exactly, then one that spills past it.
   task automatic test_full_store();
      write_trim(TRIM_NONE);
      send_run(STORE_DEPTH);
      drain_results();
      write_trim(6'd3);
      send_run(STORE_DEPTH + 6);
      drain_results();
   endtask

   task automatic test_random_runs();
      int r, t, n, k;
      while (samples_sent < RANDOM_SAMPLES) begin
         drain_results();
         r = $urandom_range(0, 9);
         if (r < 6) t = $urandom_range(0, 6);
         else if (r < 8) t = $urandom_range(7, 31);
         else if (r < 9) t = ($urandom_range(0, 1) != 0) ? 32 : int'(TRIM_MAX);
         else t = $urandom_range(0, 63);
         write_trim(TRIM_W'(t));
         for (k = $urandom_range(8, 12); k > 0 && samples_sent < RANDOM_SAMPLES; k--) begin
            sender_eager = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 75 && 2 * t + 1 <= STORE_DEPTH) begin
               n = $urandom_range(2 * t + 1,
                                  (2 * t + 13 < STORE_DEPTH) ? 2 * t + 13 : STORE_DEPTH);
            end else if (r < 90) begin
               n = $urandom_range(1, 16);
            end else if (r < 97) begin
               n = $urandom_range(17, STORE_DEPTH);
            end else begin
               n = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 8);
            end
            send_run(n);
         end
         sender_eager = 1'b0;
      end
   endtask

   initial begin : rsp_backpressure
      int span, k;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(100, 400)) @(posedge clock);
         end else begin
            for (k = 0; k < 40; k++) begin
               span = idle_length();
               if (span > 0) begin
                  rsp_stall <= 1'b1;
                  repeat (span) @(posedge clock);
               end
               rsp_stall <= 1'b0;
               @(posedge clock);
            end
         end
      end
   end

   // Each result beat is matched against the oldest outstanding prediction.
   always @(posedge clock) begin : check_results
      tm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_means.size() == 0) begin
            report_mismatch("result with nothing outstanding, mean", '0, rsp_data.mean);
         end else begin
            want = expected_means.pop_front();
            if (rsp_data.mean !== want.mean)
               report_mismatch("mean", want.mean, rsp_data.mean);
            if (rsp_data.mean_valid !== want.mean_valid)
               report_mismatch("mean_valid", 32'(want.mean_valid), 32'(rsp_data.mean_valid));
            if (rsp_data.overflowed !== want.overflowed)
               report_mismatch("overflowed", 32'(want.overflowed), 32'(rsp_data.overflowed));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      test_random_runs();
      drain_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== trimmed_mean.f =====
rtl/tm_pkg.sv
rtl/tm_div.sv
rtl/trimmed_mean.sv
rtl/tm_check.sv
tb/tb_top.sv
